FILE: rtl/core/cart_header_validator_unit_defines.svh
// Assertion macros for the cartridge header validator RTL.
// Included by the modules that assert; no other dependencies.
`ifndef CART_HEADER_VALIDATOR_UNIT_DEFINES_SVH
`define CART_HEADER_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CHV_ASSERT(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("chv assertion failed");
`define CHV_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("chv assertion failed");
`else
`define CHV_ASSERT(label, clk_sig, rstn_sig, prop)
`define CHV_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)
`endif

`endif

FILE: rtl/core/chv_pkg.sv
// Shared types, header offsets and decode tables for the cartridge header validator.
// No dependencies.
package chv_pkg;

    localparam int POSITION_BITS = 23;

    typedef logic [POSITION_BITS-1:0] pos_t;

    localparam pos_t POS_MAX         = '1;
    localparam pos_t ADDR_LOGO_FIRST = pos_t'(12'h104);
    localparam pos_t ADDR_HDR_FIRST  = pos_t'(12'h134);
    localparam pos_t ADDR_COLOR      = pos_t'(12'h143);
    localparam pos_t ADDR_TYPE       = pos_t'(12'h147);
    localparam pos_t ADDR_ROM_SIZE   = pos_t'(12'h148);
    localparam pos_t ADDR_RAM_SIZE   = pos_t'(12'h149);
    localparam pos_t ADDR_REGION     = pos_t'(12'h14A);
    localparam pos_t ADDR_HDR_LAST   = pos_t'(12'h14C);
    localparam pos_t ADDR_HDR_CHECK  = pos_t'(12'h14D);
    localparam pos_t ADDR_GCHK_HI    = pos_t'(12'h14E);
    localparam pos_t ADDR_GCHK_LO    = pos_t'(12'h14F);

    localparam int COLOR_BIT = 7;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LOGO   = 3'd1,
        ST_HEADER = 3'd2,
        ST_GLOBAL = 3'd3,
        ST_SHORT  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        MAP_NONE   = 4'd0,
        MAP_MBC1   = 4'd1,
        MAP_MBC2   = 4'd2,
        MAP_MMM01  = 4'd3,
        MAP_MBC3   = 4'd4,
        MAP_MBC5   = 4'd5,
        MAP_MBC6   = 4'd6,
        MAP_MBC7   = 4'd7,
        MAP_CAMERA = 4'd8,
        MAP_TAMA5  = 4'd9,
        MAP_HUC3   = 4'd10,
        MAP_HUC1   = 4'd11
    } mapper_kind_t;

    typedef struct packed {
        status_t     status;
        logic        color;
        logic [7:0]  type_code;
        logic [7:0]  size_code;
        logic [7:0]  ram_code;
        logic [7:0]  region;
        logic [7:0]  version;
    } scan_summary_t;

    typedef struct packed {
        mapper_kind_t mapper;
        logic         ram;
        logic         battery;
        logic         timer;
        logic         rumble;
        logic         sensor;
    } type_info_t;

    typedef struct packed {
        status_t      status;
        logic         color;
        type_info_t   info;
        logic [7:0]   size_code;
        logic [4:0]   ram_banks;
        logic [7:0]   region;
        logic [7:0]   version;
    } result_t;

    function automatic logic [7:0] logo_byte(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'hCE;  6'd1:  v = 8'hED;  6'd2:  v = 8'h66;  6'd3:  v = 8'h66;
            6'd4:  v = 8'hCC;  6'd5:  v = 8'h0D;  6'd6:  v = 8'h00;  6'd7:  v = 8'h0B;
            6'd8:  v = 8'h03;  6'd9:  v = 8'h73;  6'd10: v = 8'h00;  6'd11: v = 8'h83;
            6'd12: v = 8'h00;  6'd13: v = 8'h0C;  6'd14: v = 8'h00;  6'd15: v = 8'h0D;
            6'd16: v = 8'h00;  6'd17: v = 8'h08;  6'd18: v = 8'h11;  6'd19: v = 8'h1F;
            6'd20: v = 8'h88;  6'd21: v = 8'h89;  6'd22: v = 8'h00;  6'd23: v = 8'h0E;
            6'd24: v = 8'hDC;  6'd25: v = 8'hCC;  6'd26: v = 8'h6E;  6'd27: v = 8'hE6;
            6'd28: v = 8'hDD;  6'd29: v = 8'hDD;  6'd30: v = 8'hD9;  6'd31: v = 8'h99;
            6'd32: v = 8'hBB;  6'd33: v = 8'hBB;  6'd34: v = 8'h67;  6'd35: v = 8'h63;
            6'd36: v = 8'h6E;  6'd37: v = 8'h0E;  6'd38: v = 8'hEC;  6'd39: v = 8'hCC;
            6'd40: v = 8'hDD;  6'd41: v = 8'hDC;  6'd42: v = 8'h99;  6'd43: v = 8'h9F;
            6'd44: v = 8'hBB;  6'd45: v = 8'hB9;  6'd46: v = 8'h33;  6'd47: v = 8'h3E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // feature vector: {sensor, rumble, timer, battery, ram}
    function automatic type_info_t decode_type(input logic [7:0] code);
        type_info_t   t;
        mapper_kind_t m;
        logic [4:0]   f;
        m = MAP_NONE;
        f = 5'b00000;
        case (code)
            8'h01: m = MAP_MBC1;
            8'h02: begin m = MAP_MBC1; f = 5'b00001; end
            8'h03: begin m = MAP_MBC1; f = 5'b00011; end
            8'h05: m = MAP_MBC2;
            8'h06: begin m = MAP_MBC2; f = 5'b00010; end
            8'h08: f = 5'b00001;
            8'h09: f = 5'b00011;
            8'h0B: m = MAP_MMM01;
            8'h0C: begin m = MAP_MMM01; f = 5'b00001; end
            8'h0D: begin m = MAP_MMM01; f = 5'b00011; end
            8'h0F: begin m = MAP_MBC3; f = 5'b00110; end
            8'h10: begin m = MAP_MBC3; f = 5'b00111; end
            8'h11: m = MAP_MBC3;
            8'h12: begin m = MAP_MBC3; f = 5'b00001; end
            8'h13: begin m = MAP_MBC3; f = 5'b00011; end
            8'h19: m = MAP_MBC5;
            8'h1A: begin m = MAP_MBC5; f = 5'b00001; end
            8'h1B: begin m = MAP_MBC5; f = 5'b00011; end
            8'h1C: begin m = MAP_MBC5; f = 5'b01000; end
            8'h1D: begin m = MAP_MBC5; f = 5'b01001; end
            8'h1E: begin m = MAP_MBC5; f = 5'b01011; end
            8'h20: m = MAP_MBC6;
            8'h22: begin m = MAP_MBC7; f = 5'b11011; end
            8'hFC: m = MAP_CAMERA;
            8'hFD: m = MAP_TAMA5;
            8'hFE: m = MAP_HUC3;
            8'hFF: begin m = MAP_HUC1; f = 5'b00011; end
            default: ;
        endcase
        t.mapper  = m;
        t.ram     = f[0];
        t.battery = f[1];
        t.timer   = f[2];
        t.rumble  = f[3];
        t.sensor  = f[4];
        return t;
    endfunction

    function automatic logic [4:0] ram_banks(input logic [7:0] code);
        logic [4:0] n;
        case (code)
            8'h02:   n = 5'd1;
            8'h03:   n = 5'd4;
            8'h04:   n = 5'd16;
            8'h05:   n = 5'd8;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/chv_scan.sv
// Running image state: byte offset, logo compare, header and global checksums,
// captured header bytes. Depends on chv_pkg and the assertion macro header.
`include "cart_header_validator_unit_defines.svh"

module chv_scan
    import chv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    rom_byte,
    input  logic          last,
    output scan_summary_t summary
);

    pos_t        pos_reg, pos_next;
    logic        logo_good_reg, logo_good_next;
    logic [7:0]  header_sum_reg, header_sum_next;
    logic [15:0] global_sum_reg, global_sum_next;
    logic [15:0] gcheck_reg, gcheck_next;
    logic [7:0]  hcheck_reg, hcheck_next;
    logic        color_reg, color_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  size_reg, size_next;
    logic [7:0]  ram_code_reg, ram_code_next;
    logic [7:0]  region_reg, region_next;
    logic [7:0]  version_reg, version_next;

    pos_t        logo_off;
    logic        in_logo;
    logic        in_hdr;

    assign logo_off = pos_reg - ADDR_LOGO_FIRST;
    assign in_logo  = (pos_reg >= ADDR_LOGO_FIRST) && (pos_reg < ADDR_HDR_FIRST);
    assign in_hdr   = (pos_reg >= ADDR_HDR_FIRST) && (pos_reg <= ADDR_HDR_LAST);

    always_comb
    begin
        logo_good_next  = logo_good_reg &
                          !(in_logo && (rom_byte != logo_byte(logo_off[5:0])));
        header_sum_next = in_hdr ? (header_sum_reg - rom_byte - 8'd1) : header_sum_reg;
        gcheck_next     = gcheck_reg;
        global_sum_next = global_sum_reg;
        if (pos_reg == ADDR_GCHK_HI)
        begin
            gcheck_next[15:8] = rom_byte;
        end
        else if (pos_reg == ADDR_GCHK_LO)
        begin
            gcheck_next[7:0] = rom_byte;
        end
        else
        begin
            global_sum_next = global_sum_reg + {8'd0, rom_byte};
        end

        color_next    = color_reg;
        type_next     = type_reg;
        size_next     = size_reg;
        ram_code_next = ram_code_reg;
        region_next   = region_reg;
        version_next  = version_reg;
        hcheck_next   = hcheck_reg;
        case (pos_reg)
            ADDR_COLOR:     color_next    = rom_byte[COLOR_BIT];
            ADDR_TYPE:      type_next     = rom_byte;
            ADDR_ROM_SIZE:  size_next     = rom_byte;
            ADDR_RAM_SIZE:  ram_code_next = rom_byte;
            ADDR_REGION:    region_next   = rom_byte;
            ADDR_HDR_LAST:  version_next  = rom_byte;
            ADDR_HDR_CHECK: hcheck_next   = rom_byte;
            default: ;
        endcase

        pos_next = (pos_reg != POS_MAX) ? (pos_reg + pos_t'(1)) : pos_reg;
    end

    always_comb
    begin
        if (pos_reg < ADDR_GCHK_LO)
        begin
            summary.status = ST_SHORT;
        end
        else if (global_sum_next != gcheck_next)
        begin
            summary.status = ST_GLOBAL;
        end
        else if (header_sum_next != hcheck_next)
        begin
            summary.status = ST_HEADER;
        end
        else if (!logo_good_next)
        begin
            summary.status = ST_LOGO;
        end
        else
        begin
            summary.status = ST_OK;
        end
        summary.color     = color_next;
        summary.type_code = type_next;
        summary.size_code = size_next;
        summary.ram_code  = ram_code_next;
        summary.region    = region_next;
        summary.version   = version_next;
    end

    // the final byte of an image returns everything to the start-of-image values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            logo_good_reg  <= 1'b1;
            header_sum_reg <= '0;
            global_sum_reg <= '0;
            gcheck_reg     <= '0;
            hcheck_reg     <= '0;
            color_reg      <= 1'b0;
            type_reg       <= '0;
            size_reg       <= '0;
            ram_code_reg   <= '0;
            region_reg     <= '0;
            version_reg    <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                pos_reg        <= '0;
                logo_good_reg  <= 1'b1;
                header_sum_reg <= '0;
                global_sum_reg <= '0;
                gcheck_reg     <= '0;
                hcheck_reg     <= '0;
                color_reg      <= 1'b0;
                type_reg       <= '0;
                size_reg       <= '0;
                ram_code_reg   <= '0;
                region_reg     <= '0;
                version_reg    <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                logo_good_reg  <= logo_good_next;
                header_sum_reg <= header_sum_next;
                global_sum_reg <= global_sum_next;
                gcheck_reg     <= gcheck_next;
                hcheck_reg     <= hcheck_next;
                color_reg      <= color_next;
                type_reg       <= type_next;
                size_reg       <= size_next;
                ram_code_reg   <= ram_code_next;
                region_reg     <= region_next;
                version_reg    <= version_next;
            end
        end
    end

    `CHV_ASSERT_NEXT(a_image_restart, clk, rst_n, fire && last,
                     (pos_reg == '0) && logo_good_reg && (global_sum_reg == '0))
    `CHV_ASSERT_NEXT(a_pos_advance, clk, rst_n, fire && !last && (pos_reg != POS_MAX),
                     pos_reg == ($past(pos_reg) + pos_t'(1)))

endmodule

FILE: rtl/core/cart_header_validator_unit.sv
// Top level of the cartridge header validator: input word register, scan state,
// type decode and result register. Depends on chv_pkg, chv_scan and the macro header.
//
// Streams a cartridge image one byte word per clock, offset 0 first, and returns one
// result word when the word marked last_byte has been processed. Throughput is one byte
// per cycle unless byte_stall is high: the checksums, logo compare and header capture
// all update in the single stage behind the input register. A final byte's result is
// registered as the byte leaves that register. byte_stall rises only when a final byte
// waits there while the previous result is held by result_stall; non-final bytes flow.
`include "cart_header_validator_unit_defines.svh"

module cart_header_validator_unit
    import chv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rom_byte,
    input  logic        last_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic        supports_color,
    output logic [3:0]  mapper_kind,
    output logic        has_ram,
    output logic        has_battery,
    output logic        has_timer,
    output logic        has_rumble,
    output logic        has_sensor,
    output logic [7:0]  rom_size_code,
    output logic [4:0]  ram_bank_count,
    output logic [7:0]  destination_code,
    output logic [7:0]  version_number
);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_last_reg;
    logic          result_valid_reg;
    result_t       result_reg, result_next;

    logic          byte_accept;
    logic          out_free;
    logic          s1_fire;
    scan_summary_t summary;
    type_info_t    info;

    assign out_free    = !result_valid_reg || !result_stall;
    assign s1_fire     = s1_valid_reg && (!s1_last_reg || out_free);
    assign byte_stall  = s1_valid_reg && !s1_fire;
    assign byte_accept = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_byte_reg <= rom_byte;
            s1_last_reg <= last_byte;
        end
    end

    chv_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (s1_fire),
        .rom_byte (s1_byte_reg),
        .last     (s1_last_reg),
        .summary  (summary)
    );

    always_comb
    begin
        info                  = decode_type(summary.type_code);
        result_next.status    = summary.status;
        result_next.color     = summary.color;
        result_next.info      = info;
        result_next.size_code = summary.size_code;
        result_next.ram_banks = info.ram ? ram_banks(summary.ram_code) : 5'd0;
        result_next.region    = summary.region;
        result_next.version   = summary.version;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid     = result_valid_reg;
    assign status           = result_reg.status;
    assign supports_color   = result_reg.color;
    assign mapper_kind      = result_reg.info.mapper;
    assign has_ram          = result_reg.info.ram;
    assign has_battery      = result_reg.info.battery;
    assign has_timer        = result_reg.info.timer;
    assign has_rumble       = result_reg.info.rumble;
    assign has_sensor       = result_reg.info.sensor;
    assign rom_size_code    = result_reg.size_code;
    assign ram_bank_count   = result_reg.ram_banks;
    assign destination_code = result_reg.region;
    assign version_number   = result_reg.version;

    `CHV_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_fire && s1_last_reg,
                     result_valid_reg)
    `CHV_ASSERT(a_stall_cause, clk, rst_n,
                !byte_stall || (s1_last_reg && result_valid_reg && result_stall))

endmodule
